// ===== design/b64e_pkg.sv =====
// shared types, constants and alphabet lookup for the base64 stream encoder
package b64e_pkg;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // ascii code of the pad character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // position of the next byte within its 3-byte group
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } group_pos_t;

    // input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // output transfer payload
    typedef struct packed {
        logic [7:0] symbol_char;
        logic       end_of_message;
    } out_item_t;

    // one classified byte: its symbols, pad count and end flag
    typedef struct packed {
        logic [5:0] sextet0;
        logic [5:0] sextet1;
        logic [1:0] n_sym;    // 1 or 2 alphabet symbols
        logic [1:0] n_pad;    // 0 to 2 pad characters after them
        logic       eom;      // final result of this job ends the message
    } job_t;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            c = 8'h2F;
            if (v < 6'd26)
            begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62)
            begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            return c;
        end
    endfunction

endpackage

// ===== design/b64e_front.sv =====
// front part: group position tracking and byte classification into jobs
module b64e_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  b64e_pkg::in_item_t item,
    output b64e_pkg::job_t    job
);
    import b64e_pkg::*;

    group_pos_t group_pos_reg;
    group_pos_t group_pos_next;
    logic [3:0] leftover_reg;
    logic [3:0] leftover_next;

    // next group position and leftover bits
    always_comb
    begin
        group_pos_next = POS_FIRST;
        leftover_next  = 4'd0;
        case (group_pos_reg)
            POS_SECOND:
            begin
                if (!item.last_byte)
                begin
                    leftover_next  = item.data_byte[3:0];
                    group_pos_next = POS_THIRD;
                end
            end
            POS_THIRD:
            begin
                // group closes
                group_pos_next = POS_FIRST;
            end
            default:
            begin
                // first byte of a group, also the unused position code
                if (!item.last_byte)
                begin
                    leftover_next  = {2'b00, item.data_byte[1:0]};
                    group_pos_next = POS_SECOND;
                end
            end
        endcase
    end

    // classify the byte against the current group position
    always_comb
    begin
        job = '0;
        case (group_pos_reg)
            POS_SECOND:
            begin
                job.sextet0 = {leftover_reg[1:0], item.data_byte[7:4]};
                job.sextet1 = {item.data_byte[3:0], 2'b00};
                if (item.last_byte)
                begin
                    job.n_sym = 2'd2;
                    job.n_pad = 2'd1;
                    job.eom   = 1'b1;
                end
                else
                begin
                    job.n_sym = 2'd1;
                end
            end
            POS_THIRD:
            begin
                job.sextet0 = {leftover_reg, item.data_byte[7:6]};
                job.sextet1 = item.data_byte[5:0];
                job.n_sym   = 2'd2;
                job.eom     = item.last_byte;
            end
            default:
            begin
                job.sextet0 = item.data_byte[7:2];
                job.sextet1 = {item.data_byte[1:0], 4'b0000};
                if (item.last_byte)
                begin
                    job.n_sym = 2'd2;
                    job.n_pad = 2'd2;
                    job.eom   = 1'b1;
                end
                else
                begin
                    job.n_sym = 2'd1;
                end
            end
        endcase
    end

    // group state advances on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg <= POS_FIRST;
            leftover_reg  <= 4'd0;
        end
        else if (accept)
        begin
            group_pos_reg <= group_pos_next;
            leftover_reg  <= leftover_next;
        end
    end

endmodule

// ===== design/b64e_queue.sv =====
// short job queue between the front and back parts
module b64e_queue #(
    parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64e_pkg::job_t  push_job,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output b64e_pkg::job_t  head_job
);
    import b64e_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(Depth - 1);

    job_t          slots_reg [Depth];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    // fill count stays in range
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(Depth))
        else $error("queue count above depth");
    // never written while full unless a slot frees in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) (push && full) |-> pop)
        else $error("push into full queue");
    // never read while empty
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== design/b64e_back.sv =====
// back part: walks each job one symbol per free cycle into the output register
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64e_pkg::job_t      head_job,
    output logic                pop,
    output logic                sym_valid,
    input  logic                sym_stall,
    output b64e_pkg::out_item_t sym_item
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    out_item_t  out_next;
    logic       out_free;
    logic       load;
    logic [2:0] total;
    logic       is_final;

    assign out_free = !out_valid_reg || !sym_stall;
    assign load     = out_free && head_valid;
    assign total    = {1'b0, head_job.n_sym} + {1'b0, head_job.n_pad};
    assign is_final = ({1'b0, idx_reg} == (total - 3'd1));
    assign pop      = load && is_final;

    // pick the symbol at the current index of the head job
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = head_valid;
        end
        if (load)
        begin
            if (idx_reg == 2'd0)
            begin
                out_next.symbol_char = b64_char(head_job.sextet0);
            end
            else if (idx_reg == 2'd1 && head_job.n_sym == 2'd2)
            begin
                out_next.symbol_char = b64_char(head_job.sextet1);
            end
            else
            begin
                out_next.symbol_char = PAD_CHAR;
            end
            out_next.end_of_message = head_job.eom && is_final;
            idx_next = is_final ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign sym_valid = out_valid_reg;
    assign sym_item  = out_reg;

    // a job partly sent stays at the head of the queue
    assert property (@(posedge clk) disable iff (!rst_n) (idx_reg != 2'd0) |-> head_valid)
        else $error("job left the queue before its last symbol");
    // every job carries one or two symbols
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_job.n_sym == 2'd1 || head_job.n_sym == 2'd2))
        else $error("bad symbol count in job");
    // padding only appears on the job that ends a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_job.n_pad != 2'd0) |-> head_job.eom)
        else $error("padding without end of message");
    // the index wraps to zero after the final symbol of a job
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> (idx_reg == 2'd0))
        else $error("index not cleared after job");

endmodule

// ===== design/base64_stream_encoder.sv =====
// top level of the streaming base64 encoder
//
// Input channel (byte_valid / byte_stall / byte_item) takes one message byte per
// transfer with last_byte set on the final byte of a message. Output channel
// (sym_valid / sym_stall / sym_item) delivers one ASCII symbol per transfer;
// end_of_message is set on the last symbol, after any '=' padding.
// A byte yields one symbol, two at the third byte of a group, and three or four
// when it is the last byte of a partial group (flushed bits plus padding).
// The front classifies each byte into a job in the cycle it is accepted; jobs
// wait in a small queue (QueueDepth entries) and the back part emits one symbol
// per cycle from the head job into a registered output while sym_stall is low.
// Each symbol passes through a queue slot and then the output register.
// The output gives one symbol per cycle while not stalled, four symbols per
// three bytes in a steady stream; byte_stall rises only when the queue is full.
// Reset clears the group position, the queue and the output valid flag.
// While sym_stall is high the output symbol holds and the queue fills, after
// which byte_stall holds off further input.
module base64_stream_encoder #(
    parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  b64e_pkg::in_item_t  byte_item,
    output logic                sym_valid,
    input  logic                sym_stall,
    output b64e_pkg::out_item_t sym_item
);
    import b64e_pkg::*;

    logic  accept;
    logic  full;
    logic  pop;
    logic  head_valid;
    job_t  new_job;
    job_t  head_job;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    // byte classification
    b64e_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .job    (new_job)
    );

    // job queue
    b64e_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (new_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // symbol emission
    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_item   (sym_item)
    );

endmodule

// ===== test/base64_stream_encoder_tb.sv =====
// self-checking testbench for the streaming base64 encoder
module base64_stream_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam int RANDOM_BYTES = 460;
    localparam int QUIET_AFTER  = 400;
    localparam int HOLD_CYCLES  = 48;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // expected symbol stream, predicted per accepted byte
    class symbol_scoreboard;
        out_item_t  expected_q[$];
        group_pos_t group_pos;
        logic [3:0] carry_bits;
        int         errors;
        int         checked;
        string      alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

        function new();
            group_pos  = POS_FIRST;
            carry_bits = 4'h0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void push_symbol(logic [5:0] sextet, logic eom);
            out_item_t s;
            s.symbol_char    = alphabet[int'(sextet)];
            s.end_of_message = eom;
            expected_q.push_back(s);
        endfunction

        function void push_pad(logic eom);
            out_item_t s;
            s.symbol_char    = PAD_CHAR;
            s.end_of_message = eom;
            expected_q.push_back(s);
        endfunction

        // note an accepted input transfer
        function void note_byte(in_item_t it);
            logic [7:0] b;
            b = it.data_byte;
            case (group_pos)
                POS_SECOND:
                begin
                    push_symbol({carry_bits[1:0], b[7:4]}, 1'b0);
                    if (it.last_byte)
                    begin
                        push_symbol({b[3:0], 2'b00}, 1'b0);
                        push_pad(1'b1);
                        group_pos  = POS_FIRST;
                        carry_bits = 4'h0;
                    end
                    else
                    begin
                        carry_bits = b[3:0];
                        group_pos  = POS_THIRD;
                    end
                end
                POS_THIRD:
                begin
                    push_symbol({carry_bits, b[7:6]}, 1'b0);
                    push_symbol(b[5:0], it.last_byte);
                    group_pos  = POS_FIRST;
                    carry_bits = 4'h0;
                end
                default:
                begin
                    push_symbol(b[7:2], 1'b0);
                    if (it.last_byte)
                    begin
                        push_symbol({b[1:0], 4'h0}, 1'b0);
                        push_pad(1'b0);
                        push_pad(1'b1);
                        group_pos  = POS_FIRST;
                        carry_bits = 4'h0;
                    end
                    else
                    begin
                        carry_bits = {2'b00, b[1:0]};
                        group_pos  = POS_SECOND;
                    end
                end
            endcase
        endfunction

        // compare an output transfer with the oldest expectation
        function void check_symbol(out_item_t got);
            out_item_t exp_sym;
            if (expected_q.size() == 0)
            begin
                $error("unexpected symbol 0x%02h eom %0b", got.symbol_char,
                       got.end_of_message);
                errors++;
                return;
            end
            exp_sym = expected_q.pop_front();
            checked++;
            if (got.symbol_char !== exp_sym.symbol_char)
            begin
                $error("symbol_char: expected 0x%02h, actual 0x%02h",
                       exp_sym.symbol_char, got.symbol_char);
                errors++;
            end
            if (got.end_of_message !== exp_sym.end_of_message)
            begin
                $error("end_of_message: expected %0b, actual %0b",
                       exp_sym.end_of_message, got.end_of_message);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      sym_valid;
    logic      sym_stall;
    out_item_t sym_item;

    symbol_scoreboard sb;

    bit quiet;
    bit hold_req;
    int n_bytes;
    int n_msgs;
    int holds_done;
    int pauses_done;

    base64_stream_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_item   (sym_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one byte and hold it until the transfer happens
    task automatic send_byte(input logic [7:0] d, input logic l);
        in_item_t it;
        it.data_byte = d;
        it.last_byte = l;
        byte_item  <= it;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        sb.note_byte(it);
        n_bytes++;
        if (l)
        begin
            n_msgs++;
        end
        // random sender gap
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // drop valid and wait until every expected symbol has arrived
    task automatic drain_output();
        if (byte_valid)
        begin
            byte_valid <= 1'b0;
        end
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // receiver: random stall bursts and the long hold-off on request
    initial
    begin : rx_proc
        int span;
        sym_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                sym_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sym_stall <= 1'b0;
                hold_req = 1'b0;
                holds_done++;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                span = $urandom_range(1, 3);
                sym_stall <= 1'b1;
                repeat (span) @(posedge clk);
                sym_stall <= 1'b0;
            end
        end
    end

    // output monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && sym_valid && !sym_stall)
            begin
                sb.check_symbol(sym_item);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (sym_valid && !sym_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial
    begin : main_seq
        int len;
        sb          = new();
        quiet       = 1'b0;
        hold_req    = 1'b0;
        n_bytes     = 0;
        n_msgs      = 0;
        holds_done  = 0;
        pauses_done = 0;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-byte messages at the extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte messages, one pad
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // last byte completes a group, no padding
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // group boundary crossed, then partial group flushed
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        drain_output();
        pauses_done++;

        // random messages
        while (n_bytes < RANDOM_BYTES)
        begin
            if (n_bytes >= QUIET_AFTER)
            begin
                quiet = 1'b1;
            end
            if (n_msgs == 12 || n_msgs == 60)
            begin
                // long receiver hold while bytes keep coming
                hold_req = 1'b1;
                send_message(24);
            end
            else if (n_msgs == 30 || n_msgs == 80)
            begin
                drain_output();
                pauses_done++;
                send_message($urandom_range(1, 6));
            end
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                send_message(len);
            end
        end

        drain_output();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d messages, checked %0d symbols",
                 n_bytes, n_msgs, sb.checked);
        $display("long receiver holds: %0d, sender pauses until drained: %0d",
                 holds_done, pauses_done);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
